>>> src/cdq_pkg.sv
// cdq_pkg: shared constants, codes and types for the circular deque.
// Depends on nothing; imported by the interfaces, cdq_ctrl, circular_deque and the testbench.
`default_nettype none

package cdq_pkg;

  // Sizing
  localparam int DEPTH  = 8;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 4;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_MAX  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Store access request from the controller
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> src/cdq_if.sv
// cdq_in_if / cdq_out_if: valid/ready channels for commands and results.
// Depends on cdq_pkg for field widths.
`default_nettype none

interface cdq_in_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pop_value;
  logic [STAT_W-1:0]        status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

`default_nettype wire

>>> src/circular_deque.sv
// circular_deque: top level of the double-ended queue.
// Depends on cdq_pkg, cdq_if (interfaces), cdq_ram and cdq_ctrl.
//
// Double-ended queue of DEPTH signed 32-bit words in a circular store. Each command
// transfer (push front, push back, pop front, pop back) yields exactly one result
// carrying the popped word (zero otherwise), a status (ok, full, empty) and the
// occupancy after the step; a refused push or pop changes nothing. A push or a
// refused command puts its result in the output register the cycle after the
// transfer and the next command may follow in that cycle, so pushes run at one per
// cycle while results are taken without a stall. A successful pop reads the store
// memory, whose read port is registered, and waits in S_READ; no command is taken there.
// The output register lets a new command be taken in the cycle its predecessor's
// result is taken. No clearing pass follows reset.
`default_nettype none

module circular_deque import cdq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_data;

  // Pointers, count and result register
  cdq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // Word store
  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire

>>> src/cdq_ram.sv
// cdq_ram: generic single-write, single-read synchronous RAM, registered read.
// Depends on nothing.
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/cdq_ctrl.sv
// cdq_ctrl: front/back pointers, occupancy count, store access and result register.
// Depends on cdq_pkg and the cdq_in_if / cdq_out_if interfaces.
`default_nettype none

module cdq_ctrl import cdq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  cdq_in_if.sink                 in_ch,
  cdq_out_if.source              out_ch,
  output      mem_req_t          mem_req,
  input  wire logic [DATA_W-1:0] rd_data
);

  state_t                   state_r, state_nxt;
  logic [PTR_W-1:0]         front_r, front_nxt;
  logic [PTR_W-1:0]         back_r, back_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] res_value_r;
  stat_t                    res_status_r, res_status_nxt;
  logic [OCC_W-1:0]         res_occ_r;

  cmd_t             cmd;
  logic             is_push, is_full, is_empty, accept, refused;
  logic [PTR_W-1:0] front_inc, front_dec, back_inc, back_dec;

  // Decode and pointer neighbours (both pointers wrap either way)
  assign cmd       = cmd_t'(in_ch.command);
  assign is_push   = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
  assign is_full   = (count_r == CNT_FULL);
  assign is_empty  = (count_r == '0);
  assign refused   = is_push ? is_full : is_empty;
  assign front_inc = (front_r == PTR_MAX) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? PTR_MAX : front_r - 1'b1;
  assign back_inc  = (back_r == PTR_MAX) ? '0 : back_r + 1'b1;
  assign back_dec  = (back_r == '0) ? PTR_MAX : back_r - 1'b1;

  // Take a command only when idle and the result slot is free or draining
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !is_push && !is_empty) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Store requests, pointer and count updates
  always_comb begin
    mem_req        = '0;
    mem_req.wdata  = in_ch.push_value;
    front_nxt      = front_r;
    back_nxt       = back_r;
    count_nxt      = count_r;
    res_status_nxt = STAT_OK;
    if (refused) begin
      res_status_nxt = is_push ? STAT_FULL : STAT_EMPTY;
    end
    if (accept && !refused) begin
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          mem_req.we    = 1'b1;
          mem_req.waddr = front_dec;
          front_nxt     = front_dec;
          count_nxt     = count_r + 1'b1;
        end
        CMD_PUSH_BACK: begin
          mem_req.we    = 1'b1;
          mem_req.waddr = back_r;
          back_nxt      = back_inc;
          count_nxt     = count_r + 1'b1;
        end
        CMD_POP_FRONT: begin
          mem_req.re    = 1'b1;
          mem_req.raddr = front_r;
          front_nxt     = front_inc;
          count_nxt     = count_r - 1'b1;
        end
        CMD_POP_BACK: begin
          mem_req.re    = 1'b1;
          mem_req.raddr = back_dec;
          back_nxt      = back_dec;
          count_nxt     = count_r - 1'b1;
        end
        default: begin
          mem_req.we = 1'b0;
        end
      endcase
    end
  end

  // Result slot: filled at a transfer that needs no read, or once read data lands
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if ((accept && state_nxt == S_IDLE) || state_r == S_READ) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_value_r  <= '0;
      res_status_r <= res_status_nxt;
      res_occ_r    <= OCC_W'(count_nxt);
    end else if (state_r == S_READ) begin
      res_value_r  <= $signed(rd_data);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pop_value = res_value_r;
  assign out_ch.status    = res_status_r;
  assign out_ch.occupancy = res_occ_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("occupancy count above depth");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_FULL) |-> (front_r == back_r))
    else $error("pointers apart while deque empty or full");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("store written and read for one command");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (out_valid_r && state_r == S_IDLE))
    else $error("pop read did not yield a result");

  a_read_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !in_ch.ready)
    else $error("command taken during pop read");

endmodule

`default_nettype wire

>>> test/testbench.sv
// testbench: self-checking bench for circular_deque, driving commands with random gaps
// and result back-pressure and checking every result against an in-bench deque predictor.
// Depends on cdq_pkg, cdq_in_if / cdq_out_if and the circular_deque RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 450;
  localparam int HOLD_CYCLES   = 40;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 20;

  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // One result as the deque should report it
  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    stat_t                    status;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  logic clk;
  logic rst_n;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: a mirror of the deque
  logic signed [DATA_W-1:0] mirror_slots [DEPTH];
  logic [PTR_W-1:0]         mirror_front;
  logic [PTR_W-1:0]         mirror_back;
  int unsigned              mirror_fill;

  deque_result_t pending_results [$];

  int error_count;
  int cycle_count;
  int hold_token;
  bit sender_gaps_on;
  bit receiver_stalls_on;
  int cmd_tally [4];
  int full_refusals;
  int empty_refusals;
  int wraps_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [PTR_W-1:0] slot_after(logic [PTR_W-1:0] p);
    return (p == PTR_MAX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] slot_before(logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_MAX : p - 1'b1;
  endfunction

  // Apply one command to the mirror and return the result it should give
  function automatic deque_result_t apply_command(cmd_t cmd, logic signed [DATA_W-1:0] value);
    deque_result_t r;
    r.pop_value = '0;
    r.status    = STAT_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (mirror_fill == DEPTH) begin
          r.status = STAT_FULL;
          full_refusals++;
        end else if (cmd == CMD_PUSH_FRONT) begin
          if (mirror_front == '0) wraps_seen++;
          mirror_front = slot_before(mirror_front);
          mirror_slots[mirror_front] = value;
          mirror_fill++;
        end else begin
          mirror_slots[mirror_back] = value;
          if (mirror_back == PTR_MAX) wraps_seen++;
          mirror_back = slot_after(mirror_back);
          mirror_fill++;
        end
      end
      default: begin
        if (mirror_fill == 0) begin
          r.status = STAT_EMPTY;
          empty_refusals++;
        end else if (cmd == CMD_POP_FRONT) begin
          r.pop_value = mirror_slots[mirror_front];
          if (mirror_front == PTR_MAX) wraps_seen++;
          mirror_front = slot_after(mirror_front);
          mirror_fill--;
        end else begin
          if (mirror_back == '0) wraps_seen++;
          mirror_back = slot_before(mirror_back);
          r.pop_value = mirror_slots[mirror_back];
          mirror_fill--;
        end
      end
    endcase
    r.occupancy = OCC_W'(mirror_fill);
    return r;
  endfunction

  function automatic void report_field(string field, longint want, longint got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endfunction

  // Result checker and predictor; both sides sampled at the same edge
  always @(posedge clk) begin : scoreboard
    deque_result_t want;
    cmd_t          cmd;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got value %0d status %0d occ %0d",
                     $time, out_ch.pop_value, out_ch.status, out_ch.occupancy);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.pop_value !== want.pop_value)
            report_field("pop_value", want.pop_value, out_ch.pop_value);
          if (out_ch.status !== want.status)
            report_field("status", want.status, out_ch.status);
          if (out_ch.occupancy !== want.occupancy)
            report_field("occupancy", want.occupancy, out_ch.occupancy);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cmd = cmd_t'(in_ch.command);
        cmd_tally[cmd]++;
        pending_results.push_back(apply_command(cmd, in_ch.push_value));
      end
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  // Result receiver: random stalls plus the long hold-off on request
  initial begin : receiver
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (receiver_stalls_on && $urandom_range(0, 99) < 20) begin
        stall_left = pick_idle_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one command and hold it until the transfer; valid stays high afterwards
  task automatic send_command(cmd_t cmd, logic signed [DATA_W-1:0] value);
    int gap;
    gap = 0;
    if (sender_gaps_on && $urandom_range(0, 99) >= 50) gap = pick_idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.push_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_t pick_command(int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
  endfunction

  // Refused pops on empty, extreme words, fill to full, refused pushes, drain from both ends
  task automatic check_refusals_and_extremes();
    send_command(CMD_POP_FRONT, WORD_MAX);
    send_command(CMD_POP_BACK, WORD_MIN);
    send_command(CMD_PUSH_BACK, WORD_MAX);
    send_command(CMD_PUSH_FRONT, WORD_MIN);
    send_command(CMD_PUSH_BACK, '0);
    send_command(CMD_PUSH_FRONT, '1);
    send_command(CMD_PUSH_BACK, 32'h5555_5555);
    send_command(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_command(CMD_PUSH_BACK, 32'sd1);
    send_command(CMD_PUSH_FRONT, WORD_MIN + 1);
    send_command(CMD_PUSH_BACK, 32'h1234_5678);
    send_command(CMD_PUSH_FRONT, 32'h8765_4321);
    repeat (4) send_command(CMD_POP_FRONT, '0);
    repeat (4) send_command(CMD_POP_BACK, '1);
    send_command(CMD_POP_BACK, '0);
  endtask

  // Front and back pointers each wrapping below zero, then back up past the top slot
  task automatic check_pointer_wrap();
    send_command(CMD_PUSH_FRONT, 32'h0BAD_F00D);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_PUSH_BACK, 32'h7EED_BEEF);
    send_command(CMD_POP_FRONT, '0);
  endtask

  // Receiver holds off while commands keep coming, so the deque stalls its input
  task automatic check_output_backpressure();
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    hold_token++;
    for (int i = 0; i < 12; i++) send_command(pick_command(100), pick_value());
    for (int i = 0; i < 12; i++) send_command(pick_command(0), pick_value());
  endtask

  // Bursts leaning to pushes, leaning to pops or balanced, so the deque swings between empty and full
  task automatic check_random_traffic();
    int issued;
    int burst_len;
    int push_pct;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      sender_gaps_on     = ($urandom_range(0, 3) != 0);
      receiver_stalls_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      burst_len = $urandom_range(4, 24);
      for (int i = 0; i < burst_len; i++) send_command(pick_command(push_pct), pick_value());
      issued += burst_len;
    end
  endtask

  // Main sequence
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_PUSH_FRONT;
    in_ch.push_value   <= '0;
    error_count        = 0;
    hold_token         = 0;
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    cmd_tally          = '{default: 0};
    full_refusals      = 0;
    empty_refusals     = 0;
    wraps_seen         = 0;
    mirror_front       = '0;
    mirror_back        = '0;
    mirror_fill        = 0;
    foreach (mirror_slots[i]) mirror_slots[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_refusals_and_extremes();
    check_pointer_wrap();
    check_output_backpressure();
    check_random_traffic();

    // Let the last results drain
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Commands: %0d push front, %0d push back, %0d pop front, %0d pop back",
             cmd_tally[CMD_PUSH_FRONT], cmd_tally[CMD_PUSH_BACK],
             cmd_tally[CMD_POP_FRONT], cmd_tally[CMD_POP_BACK]);
    $display("Refused: %0d on full, %0d on empty; pointer wraps %0d; errors %0d",
             full_refusals, empty_refusals, wraps_seen, error_count);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> circular_deque.f
src/cdq_pkg.sv
src/cdq_if.sv
src/cdq_ram.sv
src/cdq_ctrl.sv
src/circular_deque.sv
test/testbench.sv
